FILE: rtl/mhcc_pkg.sv
// Shared types, codes and helpers for the multitype hardcore conflict check.
`timescale 1ns / 1ps
package mhcc_pkg;

  // Field widths fixed by the stream payload
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 10;
  localparam int POS_W    = 16;
  localparam int KIND_W   = 2;
  localparam int R2_W     = 34;
  localparam int COUNT_W  = 11;
  localparam int PERIOD_W = 16;
  localparam int SQ_W     = 2 * POS_W;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE_POINT  = 2'd0,
    CMD_STORE_RADIUS = 2'd1,
    CMD_QUERY        = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_Y = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // One scan slot handed from the sequencer to the distance pipeline
  typedef struct packed {
    logic valid;
    logic keep;
  } issue_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } dist_status_t;

  // Fold an axis difference onto the torus when wrapping is on
  function automatic logic [POS_W-1:0] axis_gap(logic [POS_W-1:0] d,
                                                logic [PERIOD_W-1:0] p,
                                                logic wrap);
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] rest;
    g    = d;
    rest = p - d;
    if (wrap) begin
      if (p < d) begin
        g = d - p;
      end else if (rest < d) begin
        g = rest;
      end
    end
    return g;
  endfunction

endpackage

FILE: rtl/mhcc_store.sv
// Point store and squared radius table memories, registered reads.
`timescale 1ns / 1ps
module mhcc_store #(
  parameter int DEPTH  = 1024,
  parameter int AW     = 10,
  parameter int PW     = 34,
  parameter int TDEPTH = 16,
  parameter int TW     = 4
) (
  input  logic                    clk,
  input  logic                    pt_we,
  input  logic [AW-1:0]           pt_waddr,
  input  logic [PW-1:0]           pt_wdata,
  input  logic [AW-1:0]           pt_raddr,
  output logic [PW-1:0]           pt_rdata,
  input  logic                    tb_we,
  input  logic [TW-1:0]           tb_waddr,
  input  logic [mhcc_pkg::R2_W-1:0] tb_wdata,
  input  logic [TW-1:0]           tb_raddr,
  output logic [mhcc_pkg::R2_W-1:0] tb_rdata
);

  logic [PW-1:0]             pt_mem [DEPTH];
  logic [mhcc_pkg::R2_W-1:0] tb_mem [TDEPTH];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tb_mem[tb_waddr] <= tb_wdata;
    end
    tb_rdata <= tb_mem[tb_raddr];
  end

endmodule

FILE: rtl/mhcc_dist.sv
// Shared distance pipeline: gap, wrap, square, compare against radius.
`timescale 1ns / 1ps
module mhcc_dist #(
  parameter int CW        = 16,
  parameter int PW        = 34,
  parameter int TW        = 4,
  parameter int MAX_TYPES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          flush,
  input  logic [CW-1:0]                 q_x,
  input  logic [CW-1:0]                 q_y,
  input  logic [mhcc_pkg::KIND_W-1:0]   q_kind,
  input  logic                          wrap,
  input  logic [mhcc_pkg::PERIOD_W-1:0] period_x,
  input  logic [mhcc_pkg::PERIOD_W-1:0] period_y,
  input  mhcc_pkg::issue_t              issue,
  input  logic [PW-1:0]                 pt_rdata,
  output logic [TW-1:0]                 tb_raddr,
  input  logic [mhcc_pkg::R2_W-1:0]     tb_rdata,
  output mhcc_pkg::dist_status_t        status
);

  localparam int PS = mhcc_pkg::POS_W;

  logic [CW-1:0]                 qx_r;
  logic [CW-1:0]                 qy_r;
  logic [mhcc_pkg::KIND_W-1:0]   qk_r;

  logic s0_v_r, s0_keep_r;
  logic s1_v_r, s1_keep_r;
  logic s2_v_r, s2_keep_r;
  logic s3_v_r, s3_keep_r;
  logic hit_r;

  logic [PS-1:0] s1_dx_r, s1_dy_r;
  logic [PS-1:0] s2_gx_r, s2_gy_r;
  logic [mhcc_pkg::R2_W-1:0] s2_r2_r, s3_r2_r;
  logic [mhcc_pkg::SQ_W-1:0] s3_sqx_r, s3_sqy_r;

  logic [CW-1:0]               px, py;
  logic [mhcc_pkg::KIND_W-1:0] sk;
  logic [PS-1:0]               ax, ay, bx, by, dx, dy;
  logic                        qual;
  logic [7:0]                  tidx;
  logic [mhcc_pkg::R2_W-1:0]   d2;

  always_ff @(posedge clk) begin
    if (flush) begin
      qx_r <= q_x;
      qy_r <= q_y;
      qk_r <= q_kind;
    end
  end

  // Stage A: raw axis differences, type check, table address
  always_comb begin
    px   = pt_rdata[CW-1:0];
    py   = pt_rdata[2*CW-1:CW];
    sk   = pt_rdata[2*CW+mhcc_pkg::KIND_W-1:2*CW];
    ax   = PS'(qx_r);
    ay   = PS'(qy_r);
    bx   = PS'(px);
    by   = PS'(py);
    dx   = (ax > bx) ? (ax - bx) : (bx - ax);
    dy   = (ay > by) ? (ay - by) : (by - ay);
    qual = s0_keep_r && (5'(qk_r) < 5'(MAX_TYPES)) && (5'(sk) < 5'(MAX_TYPES));
    tidx = 8'(qk_r) + 8'(sk) * 8'(MAX_TYPES);
    tb_raddr = tidx[TW-1:0];
    d2   = mhcc_pkg::R2_W'(s3_sqx_r) + mhcc_pkg::R2_W'(s3_sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      s0_v_r <= issue.valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s3_v_r && s3_keep_r && (d2 < s3_r2_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_keep_r <= issue.keep;
    s1_keep_r <= qual;
    s1_dx_r   <= dx;
    s1_dy_r   <= dy;
    // Stage B: torus fold, radius arrives from the table
    s2_keep_r <= s1_keep_r;
    s2_gx_r   <= mhcc_pkg::axis_gap(s1_dx_r, period_x, wrap);
    s2_gy_r   <= mhcc_pkg::axis_gap(s1_dy_r, period_y, wrap);
    s2_r2_r   <= tb_rdata;
    // Stage C: squares
    s3_keep_r <= s2_keep_r;
    s3_sqx_r  <= s2_gx_r * s2_gx_r;
    s3_sqy_r  <= s2_gy_r * s2_gy_r;
    s3_r2_r   <= s2_r2_r;
  end

  assign status.busy = s0_v_r | s1_v_r | s2_v_r | s3_v_r;
  assign status.hit  = hit_r;

endmodule

FILE: rtl/mhcc_ctrl.sv
// Sequencer: accepts commands, walks the point slots, returns the result.
`timescale 1ns / 1ps
module mhcc_ctrl #(
  parameter int MAX_POINTS = 1024,
  parameter int AW         = 10,
  parameter int JW         = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [mhcc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [mhcc_pkg::COUNT_W-1:0]  point_count,
  input  logic                          skip_valid,
  input  logic [mhcc_pkg::SLOT_W-1:0]   skip_slot,
  input  mhcc_pkg::dist_status_t        status,
  input  logic                          out_ready,
  output logic                          in_ready,
  output logic                          flush,
  output mhcc_pkg::issue_t              issue,
  output logic [AW-1:0]                 rd_addr,
  output logic                          out_valid,
  output logic                          out_allowed,
  output logic [mhcc_pkg::CMD_W-1:0]    out_answered
);

  mhcc_pkg::state_t state_r, state_nxt;

  logic [JW-1:0]                j_r, cnt_r;
  logic                         skv_r;
  logic [mhcc_pkg::SLOT_W-1:0]  sks_r;
  logic [mhcc_pkg::CMD_W-1:0]   cmd_r;
  logic                         out_valid_r, out_allowed_r;
  logic [mhcc_pkg::CMD_W-1:0]   out_answered_r;

  logic          is_query;
  logic          load_out;
  logic [JW-1:0] pc;
  logic [JW-1:0] pc_sat;

  assign is_query = (in_cmd == mhcc_pkg::CMD_QUERY);
  assign pc       = JW'(point_count);
  assign pc_sat   = (pc > JW'(MAX_POINTS)) ? JW'(MAX_POINTS) : pc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mhcc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = is_query ? mhcc_pkg::ST_SCAN : mhcc_pkg::ST_RESP;
        end
      end
      mhcc_pkg::ST_SCAN: begin
        if (status.hit) begin
          state_nxt = mhcc_pkg::ST_RESP;
        end else if (j_r == cnt_r) begin
          state_nxt = mhcc_pkg::ST_DRAIN;
        end
      end
      mhcc_pkg::ST_DRAIN: begin
        if (status.hit || !status.busy) begin
          state_nxt = mhcc_pkg::ST_RESP;
        end
      end
      mhcc_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = mhcc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mhcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    issue.valid = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      mhcc_pkg::ST_IDLE: in_ready = 1'b1;
      mhcc_pkg::ST_SCAN: issue.valid = (j_r != cnt_r);
      mhcc_pkg::ST_RESP: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
    issue.keep = !(skv_r && (j_r == JW'(sks_r)));
    rd_addr    = j_r[AW-1:0];
    flush      = in_fire && is_query;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhcc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      j_r   <= '0;
      cnt_r <= pc_sat;
      skv_r <= skip_valid;
      sks_r <= skip_slot;
      cmd_r <= in_cmd;
    end else if (issue.valid) begin
      j_r <= j_r + JW'(1);
    end
    if (load_out) begin
      out_allowed_r  <= (cmd_r == mhcc_pkg::CMD_QUERY) ? !status.hit : 1'b1;
      out_answered_r <= cmd_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_allowed  = out_allowed_r;
  assign out_answered = out_answered_r;

endmodule

FILE: rtl/multitype_hardcore_conflict_check.sv
// Top level: stream ports, configuration registers, store, sequencer, pipeline.
// A point or radius write goes straight to the response state after acceptance.
// A query scans the stored points: the sequencer issues one stored
// point per cycle from the single point memory read port into the five-stage
// distance pipeline, and stops at the first violation found.
// Throughput: one item at a time; in_tready is high only while idle.
// Reset (rst_n, synchronous) clears the sequencer state, result valid flag and config registers;
// the point store and radius table are not cleared.
`timescale 1ns / 1ps
module multitype_hardcore_conflict_check #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_TYPES  = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // slot, pos_x, pos_y, kind, radius_sq, point_count, skip_valid, skip_slot, pad
  input  logic [mhcc_pkg::IN_DATA_W-1:0]    in_tdata,
  // command
  input  logic [mhcc_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // allowed, pad
  output logic [mhcc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // answered
  output logic [mhcc_pkg::CMD_W-1:0]        out_tuser,
  input  logic                              cfg_we,
  input  logic [mhcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mhcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW     = (COORD_BITS < mhcc_pkg::POS_W) ? COORD_BITS : mhcc_pkg::POS_W;
  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TDEPTH = MAX_TYPES * MAX_TYPES;
  localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int JW     = (AW + 1 > mhcc_pkg::COUNT_W) ? AW + 1 : mhcc_pkg::COUNT_W;
  localparam int SXW    = (AW > mhcc_pkg::SLOT_W) ? AW : mhcc_pkg::SLOT_W;
  localparam int PW     = 2 * CW + mhcc_pkg::KIND_W;

  logic [mhcc_pkg::SLOT_W-1:0]  f_slot, f_skip_slot;
  logic [mhcc_pkg::POS_W-1:0]   f_pos_x, f_pos_y;
  logic [mhcc_pkg::KIND_W-1:0]  f_kind;
  logic [mhcc_pkg::R2_W-1:0]    f_radius_sq;
  logic [mhcc_pkg::COUNT_W-1:0] f_point_count;
  logic                         f_skip_valid;

  logic periodic_r;
  logic [mhcc_pkg::PERIOD_W-1:0] period_x_r, period_y_r;

  logic                         in_fire;
  logic [SXW-1:0]               slot_x;
  logic                         pt_we, tb_we;
  logic [AW-1:0]                rd_addr;
  logic [PW-1:0]                pt_rdata;
  logic [TW-1:0]                tb_raddr;
  logic [mhcc_pkg::R2_W-1:0]    tb_rdata;
  logic                         flush;
  mhcc_pkg::issue_t             issue;
  mhcc_pkg::dist_status_t       status;
  logic                         out_allowed;

  assign f_slot        = in_tdata[9:0];
  assign f_pos_x       = in_tdata[25:10];
  assign f_pos_y       = in_tdata[41:26];
  assign f_kind        = in_tdata[43:42];
  assign f_radius_sq   = in_tdata[77:44];
  assign f_point_count = in_tdata[88:78];
  assign f_skip_valid  = in_tdata[89];
  assign f_skip_slot   = in_tdata[99:90];

  assign in_fire = in_tvalid && in_tready;
  assign slot_x  = SXW'(f_slot);

  // Drop writes that fall outside the store or the table
  assign pt_we = in_fire && (in_tuser == mhcc_pkg::CMD_STORE_POINT) &&
                 (32'(f_slot) < 32'(MAX_POINTS));
  assign tb_we = in_fire && (in_tuser == mhcc_pkg::CMD_STORE_RADIUS) &&
                 (32'(f_slot) < 32'(TDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r <= 1'b0;
      period_x_r <= '0;
      period_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mhcc_pkg::REG_PERIODIC: periodic_r <= cfg_wdata[0];
        mhcc_pkg::REG_PERIOD_X: period_x_r <= cfg_wdata;
        mhcc_pkg::REG_PERIOD_Y: period_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mhcc_store #(
    .DEPTH  (MAX_POINTS),
    .AW     (AW),
    .PW     (PW),
    .TDEPTH (TDEPTH),
    .TW     (TW)
  ) u_store (
    .clk      (clk),
    .pt_we    (pt_we),
    .pt_waddr (slot_x[AW-1:0]),
    .pt_wdata ({f_kind, f_pos_y[CW-1:0], f_pos_x[CW-1:0]}),
    .pt_raddr (rd_addr),
    .pt_rdata (pt_rdata),
    .tb_we    (tb_we),
    .tb_waddr (f_slot[TW-1:0]),
    .tb_wdata (f_radius_sq),
    .tb_raddr (tb_raddr),
    .tb_rdata (tb_rdata)
  );

  mhcc_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .JW         (JW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_cmd       (in_tuser),
    .point_count  (f_point_count),
    .skip_valid   (f_skip_valid),
    .skip_slot    (f_skip_slot),
    .status       (status),
    .out_ready    (out_tready),
    .in_ready     (in_tready),
    .flush        (flush),
    .issue        (issue),
    .rd_addr      (rd_addr),
    .out_valid    (out_tvalid),
    .out_allowed  (out_allowed),
    .out_answered (out_tuser)
  );

  mhcc_dist #(
    .CW        (CW),
    .PW        (PW),
    .TW        (TW),
    .MAX_TYPES (MAX_TYPES)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .q_x      (f_pos_x[CW-1:0]),
    .q_y      (f_pos_y[CW-1:0]),
    .q_kind   (f_kind),
    .wrap     (periodic_r),
    .period_x (period_x_r),
    .period_y (period_y_r),
    .issue    (issue),
    .pt_rdata (pt_rdata),
    .tb_raddr (tb_raddr),
    .tb_rdata (tb_rdata),
    .status   (status)
  );

  assign out_tdata = {(mhcc_pkg::OUT_DATA_W - 1)'(0), out_allowed};

endmodule

FILE: rtl/mhcc_checker.sv
// Port-level checks for the conflict check block, bound to the top level.
`timescale 1ns / 1ps
module mhcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mhcc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mhcc_pkg::CMD_W-1:0]      out_tuser
);

  // A stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting an item");

  // Only a query can report a violation
  a_write_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != mhcc_pkg::CMD_QUERY) |-> out_tdata[0])
    else $error("non-query result reports a violation");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind multitype_hardcore_conflict_check mhcc_checker u_mhcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
